>>> sv/wheel_speed_from_revolutions_assert.svh
// Assertion macros used by the wheel speed controller.
`ifndef WHEEL_SPEED_FROM_REVOLUTIONS_ASSERT_SVH
`define WHEEL_SPEED_FROM_REVOLUTIONS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WSR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wsr_pkg.sv
// Package: shared constants, result kinds and controller/datapath structs.
`timescale 1ns / 1ps
package wsr_pkg;

  localparam logic [15:0] CIRC_RESET  = 16'd2096;
  localparam logic [15:0] SPEED_DECAY = 16'd2000;
  localparam logic [15:0] SPEED_MAX   = 16'hFFFF;
  localparam int          DIV_STEPS   = 16;
  localparam int          CNT_W       = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_CAPTURE = 2'd0;
  localparam logic [1:0] KIND_DECAY   = 2'd1;
  localparam logic [1:0] KIND_FRESH   = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       scale;
    logic       check;
    logic       div_step;
    logic       write;
    logic [1:0] kind;
  } wsr_cmd_t;

  typedef struct packed {
    logic capture;
    logic same_time;
    logic sat;
    logic out_free;
  } wsr_sts_t;

endpackage

>>> sv/wheel_speed_from_revolutions.sv
// Top level: wheel speed from cumulative revolutions and event time.
// Capture and decay requests go from accept through evaluate to the write; a fresh
// speed adds multiply, scale, saturation check and 16 divide steps (one bit per cycle).
// A saturated speed skips the divide. A request is taken only after the last is written.
// A new request is taken while the previous result waits in the output register.
// Synchronous reset: circumference 2096 mm, stored count, time and speed zero.
`timescale 1ns / 1ps
module wheel_speed_from_revolutions
  import wsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,  // wheel_circumference_mm
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,      // wheel_revolutions [31:0], wheel_event_time [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // speed_m_per_h [15:0]
  output logic        m_tuser       // speed_fresh [0]
);

  wsr_cmd_t cmd;
  wsr_sts_t sts;

  wsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  wsr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

>>> sv/wsr_ctrl.sv
// Controller: evaluate; fresh: multiply, divide unless saturated; then write.
`timescale 1ns / 1ps
`include "wheel_speed_from_revolutions_assert.svh"
module wsr_ctrl
  import wsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output wsr_cmd_t cmd,
  input  wsr_sts_t sts
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_WRITE = 3'd6;

  logic [2:0]       state, state_next;
  logic [1:0]       kind, kind_next;
  logic [CNT_W-1:0] count, count_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    count_next   = count;
    cmd          = '0;
    cmd.kind     = kind;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.capture) begin
          kind_next  = KIND_CAPTURE;
          state_next = ST_WRITE;
        end else if (sts.same_time) begin
          kind_next  = KIND_DECAY;
          state_next = ST_WRITE;
        end else begin
          kind_next  = KIND_FRESH;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        count_next = '0;
        state_next = sts.sat ? ST_WRITE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count + CNT_W'(1);
        if (count == CNT_W'(DIV_STEPS - 1)) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= KIND_CAPTURE;
      count <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      count <= count_next;
    end
  end

  `WSR_ASSERT_IMP(a_write_free, clk, rst, cmd.write, sts.out_free, "write into busy output")
  `WSR_ASSERT_NEXT(a_accept_eval, clk, rst, s_tvalid && s_tready, state == ST_EVAL,
                   "accepted request not evaluated")
  `WSR_ASSERT_NEXT(a_div_start, clk, rst, state == ST_CHECK && !sts.sat,
                   state == ST_DIV && count == '0, "divide did not start clean")

endmodule

>>> sv/wsr_datapath.sv
// Datapath: state registers, speed multiply, restoring divide, output register.
`timescale 1ns / 1ps
module wsr_datapath
  import wsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tuser,
  input  wsr_cmd_t    cmd,
  output wsr_sts_t    sts
);

  logic [15:0] circ;
  logic [31:0] last_revs;
  logic [15:0] last_time;
  logic [15:0] cur_speed;
  logic [31:0] in_revs;
  logic [15:0] in_time;
  logic [47:0] prod;
  logic [62:0] num;
  logic [18:0] den;
  logic [34:0] rem;
  logic [34:0] dsh;
  logic [15:0] quo;

  logic [31:0] drev;
  logic [15:0] dt;
  logic [51:0] prod9;
  logic [15:0] decayed;

  assign drev    = in_revs - last_revs;
  assign dt      = in_time - last_time;
  assign prod9   = {1'b0, prod, 3'b000} + {4'b0000, prod};
  assign decayed = (cur_speed > SPEED_DECAY) ? (cur_speed - SPEED_DECAY) : 16'd0;

  assign sts.capture   = (last_revs == 32'd0);
  assign sts.same_time = (in_time == last_time);
  assign sts.sat       = (num >= {28'd0, den, 16'd0});
  assign sts.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      circ      <= CIRC_RESET;
      last_revs <= '0;
      last_time <= '0;
      cur_speed <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en) circ <= cfg_wr_data;
      if (cmd.write) begin
        m_tvalid <= 1'b1;
        unique case (cmd.kind)
          KIND_CAPTURE: begin
            last_revs <= in_revs;
            last_time <= in_time;
          end
          KIND_DECAY: cur_speed <= decayed;
          KIND_FRESH: begin
            cur_speed <= quo;
            last_revs <= in_revs;
            last_time <= in_time;
          end
          default: ;
        endcase
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Num = circ * drev * 18432, den = 5 * dt; quotient saturates at 16 bits.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_revs <= s_tdata[31:0];
      in_time <= s_tdata[47:32];
    end
    if (cmd.mul) prod <= 48'(circ) * 48'(drev);
    if (cmd.scale) begin
      num <= {prod9, 11'd0};
      den <= {1'b0, dt, 2'b00} + {3'b000, dt};
    end
    if (cmd.check) begin
      rem <= num[34:0];
      dsh <= {1'b0, den, 15'd0};
      quo <= sts.sat ? SPEED_MAX : 16'd0;
    end
    if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[14:0], 1'b1};
      end else begin
        quo <= {quo[14:0], 1'b0};
      end
      dsh <= {1'b0, dsh[34:1]};
    end
    if (cmd.write) begin
      unique case (cmd.kind)
        KIND_DECAY: begin
          m_tdata <= decayed;
          m_tuser <= 1'b0;
        end
        KIND_FRESH: begin
          m_tdata <= quo;
          m_tuser <= 1'b1;
        end
        default: begin
          m_tdata <= cur_speed;
          m_tuser <= 1'b0;
        end
      endcase
    end
  end

endmodule
